[hdl/vfrma_pkg.sv]
// Shared types and constants for the frame RSSI moving average unit.
package vfrma_pkg;

    localparam int RSSI_W    = 8;
    localparam int SUBTYPE_W = 8;
    localparam int OUI_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [RSSI_W-1:0]    rssi_t;
    typedef logic        [SUBTYPE_W-1:0] subtype_t;
    typedef logic        [OUI_W-1:0]     oui_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes
    localparam cfg_idx_t CFG_ACTION_SUBTYPE = 2'd0;
    localparam cfg_idx_t CFG_VENDOR_OUI     = 2'd1;

    localparam subtype_t ACTION_SUBTYPE_RST = 8'hD0;
    localparam oui_t     VENDOR_OUI_RST     = 24'h7C9EBD;

endpackage

[hdl/vfrma_ram.sv]
// Simple dual-port RAM with registered, enabled read.
module vfrma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/vendor_frame_rssi_moving_average_unit.sv]
// Top level of the frame RSSI moving average unit.
//
// Filters captured frame headers (management, action subtype, vendor OUI) and keeps a
// WINDOW-deep moving average of the RSSI of accepted frames. One request is taken every
// clock cycle unless m_ stalls; the result passes the update stage and the output register.
// The window lives in a RAM read one stage ahead of the update; the running sum and the
// reciprocal multiply that forms the mean sit in that single update stage. The first accepted
// frame defines the whole window; slots not yet rewritten since then read back as that value,
// so no clearing pass is needed after reset. Configuration writes take effect immediately and
// are only to be done while the unit is idle.
module vendor_frame_rssi_moving_average_unit
    import vfrma_pkg::*;
#(
    parameter int WINDOW = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_is_mgmt,
    input  logic [SUBTYPE_W-1:0]  s_frame_ctrl_low,
    input  logic [OUI_W-1:0]      s_sender_oui,
    input  logic signed [RSSI_W-1:0] s_rssi,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_accepted,
    output logic                  m_have_data,
    output logic signed [RSSI_W-1:0] m_average_rssi
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = RSSI_W + $clog2(WINDOW);
    // exact reciprocal: floor(n*RECIP >> SH) == floor(n/WINDOW) for n < 2^SUM_W
    localparam int SH     = SUM_W + $clog2(WINDOW);
    localparam int RCP_W  = SUM_W + 2;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam longint unsigned RECIP_L = ((longint'(1) << SH) + WINDOW - 1) / WINDOW;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

    // configuration
    subtype_t action_subtype_reg;
    oui_t     vendor_oui_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            action_subtype_reg <= ACTION_SUBTYPE_RST;
            vendor_oui_reg     <= VENDOR_OUI_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ACTION_SUBTYPE: action_subtype_reg <= cfg_wdata[SUBTYPE_W-1:0];
                CFG_VENDOR_OUI:     vendor_oui_reg     <= cfg_wdata[OUI_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: filter, slot pointer, RAM read ----------------
    logic              in_fire;
    logic              acc0;
    logic              seen0_reg;
    logic              wrapped0_reg;
    logic [SLOT_W-1:0] slot0_reg;
    rssi_t             first_rssi_reg;

    assign in_fire = s_valid && s_ready;
    assign acc0    = s_is_mgmt && (s_frame_ctrl_low == action_subtype_reg)
                     && (s_sender_oui == vendor_oui_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen0_reg    <= 1'b0;
            wrapped0_reg <= 1'b0;
            slot0_reg    <= '0;
        end else if (in_fire && acc0) begin
            if (!seen0_reg) begin
                seen0_reg <= 1'b1;
            end else if (slot0_reg == LAST_SLOT) begin
                slot0_reg    <= '0;
                wrapped0_reg <= 1'b1;
            end else begin
                slot0_reg <= slot0_reg + 1'b1;
            end
        end
    end

    // value that fills the window on the first accepted frame
    always_ff @(posedge aclk) begin
        if (in_fire && acc0 && !seen0_reg) begin
            first_rssi_reg <= s_rssi;
        end
    end

    // ---------------- stage 1: window update ----------------
    logic              p1_valid_reg;
    logic              p1_acc_reg;
    logic              p1_first_reg;
    logic              p1_use_mem_reg;
    logic              p1_seen_reg;
    logic [SLOT_W-1:0] p1_slot_reg;
    rssi_t             p1_rssi_reg;
    logic              out_free;
    logic              p1_fire;
    logic [RSSI_W-1:0] ram_rdata;

    assign out_free = !m_valid || m_ready;
    assign p1_fire  = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            p1_acc_reg     <= acc0;
            p1_first_reg   <= !seen0_reg;
            p1_use_mem_reg <= wrapped0_reg;
            p1_seen_reg    <= seen0_reg || acc0;
            p1_slot_reg    <= slot0_reg;
            p1_rssi_reg    <= s_rssi;
        end
    end

    vfrma_ram #(
        .WIDTH (RSSI_W),
        .DEPTH (WINDOW)
    ) u_window_ram (
        .aclk  (aclk),
        .we    (p1_fire && p1_acc_reg && !p1_first_reg),
        .waddr (p1_slot_reg),
        .wdata (p1_rssi_reg),
        .re    (in_fire),
        .raddr (slot0_reg),
        .rdata (ram_rdata)
    );

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_upd;
    logic signed [SUM_W-1:0] rssi_ext;
    logic signed [SUM_W-1:0] old_ext;
    rssi_t                   old_rssi;
    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic [PROD_W-1:0]       prod;
    logic [RSSI_W-1:0]       quot;
    rssi_t                   mean;
    rssi_t                   avg_reg;
    rssi_t                   avg_next;

    always_comb begin
        old_rssi = p1_use_mem_reg ? rssi_t'(ram_rdata) : first_rssi_reg;
        rssi_ext = SUM_W'(p1_rssi_reg);
        old_ext  = SUM_W'(old_rssi);
        sum_upd  = sum_reg + rssi_ext - old_ext;
        sum_neg  = sum_upd[SUM_W-1];
        sum_mag  = sum_neg ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
        prod     = PROD_W'(sum_mag) * PROD_W'(RECIP);
        quot     = prod[SH +: RSSI_W];
        mean     = sum_neg ? rssi_t'(-quot) : rssi_t'(quot);

        sum_next = sum_reg;
        avg_next = avg_reg;
        if (p1_acc_reg) begin
            if (p1_first_reg) begin
                sum_next = SUM_W'(rssi_ext * WIN_S);
                avg_next = p1_rssi_reg;
            end else begin
                sum_next = sum_upd;
                avg_next = mean;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            avg_reg <= '0;
        end else if (p1_fire) begin
            sum_reg <= sum_next;
            avg_reg <= avg_next;
        end
    end

    // ---------------- output register ----------------
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_fire) begin
            m_accepted     <= p1_acc_reg;
            m_have_data    <= p1_seen_reg;
            m_average_rssi <= avg_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[tb/vendor_frame_rssi_moving_average_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for the frame RSSI moving average unit: filter, window fill, running mean, stalls.
module vendor_frame_rssi_moving_average_unit_tb;
    import vfrma_pkg::*;

    localparam int WINDOW = 20;
    localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
    localparam cfg_idx_t CFG_SPARE_3 = 2'd3;
    localparam rssi_t RSSI_MIN = 8'sh80;
    localparam rssi_t RSSI_MAX = 8'sh7F;

    typedef struct packed {
        logic     is_mgmt;
        subtype_t fc;
        oui_t     oui;
        rssi_t    rssi;
    } frame_t;

    typedef struct packed {
        logic  accepted;
        logic  have_data;
        rssi_t avg;
    } rssi_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_is_mgmt;
    logic [SUBTYPE_W-1:0]  s_frame_ctrl_low;
    logic [OUI_W-1:0]      s_sender_oui;
    logic signed [RSSI_W-1:0] s_rssi;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_accepted;
    logic                  m_have_data;
    logic signed [RSSI_W-1:0] m_average_rssi;

    vendor_frame_rssi_moving_average_unit #(.WINDOW(WINDOW)) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_is_mgmt       (s_is_mgmt),
        .s_frame_ctrl_low(s_frame_ctrl_low),
        .s_sender_oui    (s_sender_oui),
        .s_rssi          (s_rssi),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_have_data     (m_have_data),
        .m_average_rssi  (m_average_rssi)
    );

    // predictor state
    subtype_t cfg_subtype;
    oui_t     cfg_oui;
    rssi_t    window_slots [WINDOW];
    int       slot_idx;
    int       running_sum;
    logic     seen_frame;
    rssi_t    held_avg;

    rssi_result_t pending_averages [$];
    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic rssi_result_t predict_average(frame_t f);
        rssi_result_t r;
        logic hit;
        hit = f.is_mgmt && (f.fc == cfg_subtype) && (f.oui == cfg_oui);
        if (hit) begin
            if (!seen_frame) begin
                // first hit defines the whole window, slot pointer stays put
                for (int i = 0; i < WINDOW; i++) window_slots[i] = f.rssi;
                running_sum = int'(f.rssi) * WINDOW;
                seen_frame  = 1'b1;
            end else begin
                running_sum += int'(f.rssi) - int'(window_slots[slot_idx]);
                window_slots[slot_idx] = f.rssi;
                slot_idx = (slot_idx + 1 >= WINDOW) ? 0 : slot_idx + 1;
            end
            held_avg = rssi_t'(running_sum / WINDOW);
        end
        r.accepted  = hit;
        r.have_data = seen_frame;
        r.avg       = held_avg;
        return r;
    endfunction

    function automatic frame_t make_frame(logic m, subtype_t fc, oui_t oui, rssi_t r);
        frame_t f;
        f.is_mgmt = m;
        f.fc      = fc;
        f.oui     = oui;
        f.rssi    = r;
        return f;
    endfunction

    // mostly well-formed frames, some near misses and some pure noise
    function automatic frame_t rand_frame();
        frame_t f;
        int pick;
        pick = $urandom_range(0, 99);
        f = make_frame(1'b1, cfg_subtype, cfg_oui, rssi_t'($urandom_range(0, 255)));
        if (pick < 10) begin
            f.rssi = $urandom_range(0, 1) ? RSSI_MAX : RSSI_MIN;
        end else if (pick >= 70 && pick < 85) begin
            case ($urandom_range(0, 2))
                0: f.is_mgmt = 1'b0;
                1: f.fc = f.fc ^ (subtype_t'(1) << $urandom_range(0, SUBTYPE_W - 1));
                default: f.oui = f.oui ^ (oui_t'(1) << $urandom_range(0, OUI_W - 1));
            endcase
        end else if (pick >= 85) begin
            f = make_frame(1'($urandom_range(0, 1)), subtype_t'($urandom_range(0, 255)),
                           oui_t'($urandom), rssi_t'($urandom_range(0, 255)));
        end
        return f;
    endfunction

    task automatic send_frame(frame_t f);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_is_mgmt        <= f.is_mgmt;
        s_frame_ctrl_low <= f.fc;
        s_sender_oui     <= f.oui;
        s_rssi           <= f.rssi;
        do @(posedge aclk); while (!s_ready);
        pending_averages.push_back(predict_average(f));
    endtask

    // drop valid and let every pending result come back
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        settle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ACTION_SUBTYPE: cfg_subtype = data[SUBTYPE_W-1:0];
            CFG_VENDOR_OUI:     cfg_oui     = data[OUI_W-1:0];
            default: ;
        endcase
    endtask

    // receiver: random ready, or a counted hold-off when requested
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        rssi_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_averages.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_count++;
            end else begin
                exp_r = pending_averages.pop_front();
                if (m_accepted !== exp_r.accepted) begin
                    $error("accepted: expected %0d, got %0d", exp_r.accepted, m_accepted);
                    mismatch_count++;
                end
                if (m_have_data !== exp_r.have_data) begin
                    $error("have_data: expected %0d, got %0d", exp_r.have_data, m_have_data);
                    mismatch_count++;
                end
                if (m_average_rssi !== exp_r.avg) begin
                    $error("average_rssi: expected %0d, got %0d", exp_r.avg, m_average_rssi);
                    mismatch_count++;
                end
            end
        end
    end

    // rejects before any data, then the window fill and ring updates
    task automatic test_filter_and_fill();
        send_frame(make_frame(1'b0, cfg_subtype, cfg_oui, RSSI_MAX));
        send_frame(make_frame(1'b1, 8'h00, cfg_oui, RSSI_MIN));
        send_frame(make_frame(1'b1, 8'hFF, cfg_oui, RSSI_MAX));
        send_frame(make_frame(1'b1, cfg_subtype, 24'h000000, RSSI_MAX));
        send_frame(make_frame(1'b1, cfg_subtype, 24'hFFFFFF, RSSI_MIN));
        send_frame(make_frame(1'b1, cfg_subtype, cfg_oui, RSSI_MIN));
        send_frame(make_frame(1'b1, cfg_subtype, cfg_oui, RSSI_MAX));
        send_frame(make_frame(1'b0, cfg_subtype, cfg_oui, 8'sd0));
        send_frame(make_frame(1'b1, cfg_subtype, cfg_oui, RSSI_MAX));
        send_frame(make_frame(1'b1, cfg_subtype, cfg_oui, -8'sd1));
        // wrap the ring at least once
        for (int i = 0; i < WINDOW + 3; i++)
            send_frame(make_frame(1'b1, cfg_subtype, cfg_oui, (i % 2) ? RSSI_MAX : -8'sd7));
    endtask

    task automatic test_register_extremes();
        write_register(CFG_ACTION_SUBTYPE, 24'h000000);
        write_register(CFG_VENDOR_OUI, 24'h000000);
        send_frame(make_frame(1'b1, 8'h00, 24'h000000, 8'sd1));
        send_frame(make_frame(1'b1, 8'hD0, 24'h7C9EBD, 8'sd2));
        // upper data bits of the subtype write are dropped
        write_register(CFG_ACTION_SUBTYPE, 24'hABCDFF);
        write_register(CFG_VENDOR_OUI, 24'hFFFFFF);
        // writes to unmapped indexes change nothing
        write_register(CFG_SPARE_2, 24'h123456);
        write_register(CFG_SPARE_3, 24'hFFFFFF);
        send_frame(make_frame(1'b1, 8'hFF, 24'hFFFFFF, RSSI_MIN));
        send_frame(make_frame(1'b1, 8'hCD, 24'hFFFFFF, RSSI_MAX));
        send_frame(make_frame(1'b1, 8'hFF, 24'hFFFFFE, RSSI_MAX));
    endtask

    task automatic test_random_traffic(int count, int s_pct, int r_pct, logic random_cfg);
        if (random_cfg) begin
            write_register(CFG_ACTION_SUBTYPE, CFG_DATA_W'($urandom));
            write_register(CFG_VENDOR_OUI, CFG_DATA_W'($urandom));
        end else begin
            write_register(CFG_ACTION_SUBTYPE, CFG_DATA_W'(ACTION_SUBTYPE_RST));
            write_register(CFG_VENDOR_OUI, CFG_DATA_W'(VENDOR_OUI_RST));
        end
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++) send_frame(rand_frame());
    endtask

    // long receiver hold-off while the sender keeps pushing requests
    task automatic test_backpressure();
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left = 300;
        for (int i = 0; i < 60; i++) send_frame(rand_frame());
    endtask

    initial begin
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_addr         = '0;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_is_mgmt        = 1'b0;
        s_frame_ctrl_low = '0;
        s_sender_oui     = '0;
        s_rssi           = '0;
        m_ready          = 1'b0;
        mismatch_count   = 0;
        stall_left       = 0;
        send_idle_pct    = 31;
        recv_idle_pct    = 52;
        cfg_subtype      = ACTION_SUBTYPE_RST;
        cfg_oui          = VENDOR_OUI_RST;
        slot_idx         = 0;
        running_sum      = 0;
        seen_frame       = 1'b0;
        held_avg         = '0;
        foreach (window_slots[i]) window_slots[i] = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_filter_and_fill();
        test_register_extremes();
        test_random_traffic(500, 31, 52, 1'b1);
        test_random_traffic(500, 52, 31, 1'b1);
        test_backpressure();
        test_random_traffic(450, 0, 0, 1'b0);
        settle();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
